>>> rtl/accel_tilt_roll_pitch_unit_assert.svh
// Assertion macros used by the tilt unit's top level.
// Depends on nothing; included by the top level of the tilt unit.
`ifndef ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH
`define ACCEL_TILT_ROLL_PITCH_UNIT_ASSERT_SVH

// Same-cycle implication, disabled while reset is high.
`define ATRP_ASSERT_IMPLIES(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled while reset is high.
`define ATRP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

>>> rtl/atrp_pkg.sv
// Package of the tilt unit: defaults, fixed-point formats and the arctangent table.
// Depends on nothing; used by every module of the tilt unit but the square-root cell.
`default_nettype none

package atrp_pkg;

   localparam int SAMPLE_WIDTH_DEF    = 14;
   localparam int ANGLE_FRAC_BITS_DEF = 8;
   localparam int CORDIC_STAGES_DEF   = 16;

   localparam int GUARD_BITS      = 16;
   localparam int TAB_FRAC        = 24;
   localparam int TAB_LEN         = 24;
   localparam int TAB_W           = 31;
   localparam int ACC_W           = 34;
   localparam int ROLL_LIMIT_DEG  = 180;
   localparam int PITCH_LIMIT_DEG = 90;

   localparam logic signed [ACC_W-1:0] QUARTER_TURN = ACC_W'(90 * (2 ** TAB_FRAC));

   localparam logic [TAB_W-1:0] ATAN_DEG_TAB [TAB_LEN] = '{
      31'd754974720, 31'd445687602, 31'd235489088, 31'd119537938,
      31'd60000934,  31'd30029717,  31'd15018523,  31'd7509720,
      31'd3754917,   31'd1877466,   31'd938734,    31'd469367,
      31'd234684,    31'd117342,    31'd58671,     31'd29335,
      31'd14668,     31'd7334,      31'd3667,      31'd1833,
      31'd917,       31'd458,       31'd229,       31'd115
   };

endpackage

`default_nettype wire

>>> rtl/atrp_sqrt_cell.sv
// One cell of the square-root chain: settles one bit of the root per beat.
// Depends on nothing; instantiated by the tilt unit's top level.
`default_nettype none

module atrp_sqrt_cell #(
   parameter int ROOT_W = 30,
   parameter int PASS_W = 42
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  en,
   input  logic                  prev_valid,
   input  logic [2*ROOT_W-1:0]   prev_rad,
   input  logic [ROOT_W:0]       prev_rem,
   input  logic [ROOT_W-1:0]     prev_root,
   input  logic [PASS_W-1:0]     prev_pass,
   output logic                  valid_ff,
   output logic [2*ROOT_W-1:0]   rad_ff,
   output logic [ROOT_W:0]       rem_ff,
   output logic [ROOT_W-1:0]     root_ff,
   output logic [PASS_W-1:0]     pass_ff
);

   logic [ROOT_W+2:0]   cur;
   logic [ROOT_W+2:0]   sub;
   logic [ROOT_W+3:0]   trial;
   logic                ge;
   logic [2*ROOT_W-1:0] rad_in;
   logic [ROOT_W:0]     rem_in;
   logic [ROOT_W-1:0]   root_in;

   assign cur     = {prev_rem, prev_rad[2*ROOT_W-1 -: 2]};
   assign sub     = {1'b0, prev_root, 2'b01};
   assign trial   = {1'b0, cur} - {1'b0, sub};
   assign ge      = !trial[ROOT_W+3];
   assign rem_in  = ge ? trial[ROOT_W:0] : cur[ROOT_W:0];
   assign root_in = {prev_root[ROOT_W-2:0], ge};
   assign rad_in  = {prev_rad[2*ROOT_W-3:0], 2'b00};

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         rad_ff  <= rad_in;
         rem_ff  <= rem_in;
         root_ff <= root_in;
         pass_ff <= prev_pass;
      end
   end

endmodule

`default_nettype wire

>>> rtl/atrp_prerot.sv
// Entry cell of a CORDIC chain: turns a left-half-plane vector by a quarter turn.
// Depends on atrp_pkg; instantiated by the tilt unit's top level.
`default_nettype none

module atrp_prerot import atrp_pkg::*; #(
   parameter int CORD_W = 33
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     prev_valid,
   input  logic signed [CORD_W-1:0] prev_x,
   input  logic signed [CORD_W-1:0] prev_y,
   output logic                     valid_ff,
   output logic signed [CORD_W-1:0] x_ff,
   output logic signed [CORD_W-1:0] y_ff,
   output logic signed [ACC_W-1:0]  acc_ff,
   output logic                     zero_ff
);

   logic signed [CORD_W-1:0] x_in;
   logic signed [CORD_W-1:0] y_in;
   logic signed [ACC_W-1:0]  acc_in;
   logic                     zero_in;

   always_comb begin
      zero_in = (prev_x == '0) && (prev_y == '0);
      x_in    = prev_x;
      y_in    = prev_y;
      acc_in  = '0;
      if (prev_x[CORD_W-1]) begin
         if (!prev_y[CORD_W-1]) begin
            acc_in = QUARTER_TURN;
            x_in   = prev_y;
            y_in   = -prev_x;
         end else begin
            acc_in = -QUARTER_TURN;
            x_in   = -prev_y;
            y_in   = prev_x;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         acc_ff  <= acc_in;
         zero_ff <= zero_in;
      end
   end

endmodule

`default_nettype wire

>>> rtl/atrp_cordic_cell.sv
// One vectoring CORDIC micro-rotation, fixed by its stage index.
// Depends on atrp_pkg for the arctangent table; instantiated by the top level.
`default_nettype none

module atrp_cordic_cell import atrp_pkg::*; #(
   parameter int STAGE  = 0,
   parameter int CORD_W = 33
) (
   input  logic                     clock,
   input  logic                     reset,
   input  logic                     en,
   input  logic                     prev_valid,
   input  logic signed [CORD_W-1:0] prev_x,
   input  logic signed [CORD_W-1:0] prev_y,
   input  logic signed [ACC_W-1:0]  prev_acc,
   input  logic                     prev_zero,
   output logic                     valid_ff,
   output logic signed [CORD_W-1:0] x_ff,
   output logic signed [CORD_W-1:0] y_ff,
   output logic signed [ACC_W-1:0]  acc_ff,
   output logic                     zero_ff
);

   localparam logic signed [ACC_W-1:0] STEP_ANGLE =
      $signed({{(ACC_W-TAB_W){1'b0}}, ATAN_DEG_TAB[STAGE]});

   logic signed [CORD_W-1:0] dx;
   logic signed [CORD_W-1:0] dy;
   logic signed [CORD_W-1:0] x_in;
   logic signed [CORD_W-1:0] y_in;
   logic signed [ACC_W-1:0]  acc_in;

   assign dx = prev_y >>> STAGE;
   assign dy = prev_x >>> STAGE;

   always_comb begin
      if (!prev_y[CORD_W-1]) begin
         x_in   = prev_x + dx;
         y_in   = prev_y - dy;
         acc_in = prev_acc + STEP_ANGLE;
      end else begin
         x_in   = prev_x - dx;
         y_in   = prev_y + dy;
         acc_in = prev_acc - STEP_ANGLE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else if (en) begin
         valid_ff <= prev_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (en) begin
         x_ff    <= x_in;
         y_ff    <= y_in;
         acc_ff  <= acc_in;
         zero_ff <= prev_zero;
      end
   end

endmodule

`default_nettype wire

>>> rtl/accel_tilt_roll_pitch_unit.sv
// Tilt unit: one three-axis accelerometer beat in, one roll and pitch beat out, one beat
// a cycle while the output is not stalled. A beat passes the input registers, the
// bit-per-cell square-root chain, the CORDIC chains and the output register; the whole
// pipeline holds while a result beat is stalled, so a new sample is taken in every cycle
// in which the output register is empty or its beat is taken.
`default_nettype none
`include "accel_tilt_roll_pitch_unit_assert.svh"

module accel_tilt_roll_pitch_unit import atrp_pkg::*; #(
   parameter int SAMPLE_WIDTH    = SAMPLE_WIDTH_DEF,
   parameter int ANGLE_FRAC_BITS = ANGLE_FRAC_BITS_DEF,
   parameter int CORDIC_STAGES   = CORDIC_STAGES_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_accel_x,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_accel_y,
   input  logic signed [SAMPLE_WIDTH-1:0]    req_accel_z,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [ANGLE_FRAC_BITS+8:0] rsp_roll_deg,
   output logic signed [ANGLE_FRAC_BITS+7:0] rsp_pitch_deg
);

   localparam int ROOT_W  = SAMPLE_WIDTH + GUARD_BITS;
   localparam int CORD_W  = SAMPLE_WIDTH + GUARD_BITS + 3;
   localparam int SQ_W    = 2 * SAMPLE_WIDTH;
   localparam int PASS_W  = 3 * SAMPLE_WIDTH;
   localparam int ROLL_W  = ANGLE_FRAC_BITS + 9;
   localparam int PITCH_W = ANGLE_FRAC_BITS + 8;
   localparam int RND_SH  = TAB_FRAC - ANGLE_FRAC_BITS;
   localparam logic signed [ACC_W-1:0] ROUND_HALF = ACC_W'(2 ** (RND_SH - 1));
   localparam logic signed [ACC_W-1:0] ROLL_LIM   =
      ACC_W'(ROLL_LIMIT_DEG * (2 ** ANGLE_FRAC_BITS));
   localparam logic signed [ACC_W-1:0] PITCH_LIM  =
      ACC_W'(PITCH_LIMIT_DEG * (2 ** ANGLE_FRAC_BITS));

   logic adv;

   logic                           v0_ff;
   logic signed [SAMPLE_WIDTH-1:0] x0_ff;
   logic signed [SAMPLE_WIDTH-1:0] y0_ff;
   logic signed [SAMPLE_WIDTH-1:0] z0_ff;

   logic signed [SQ_W-1:0] py_in;
   logic signed [SQ_W-1:0] pz_in;
   logic                   v1_ff;
   logic [SQ_W-1:0]        py1_ff;
   logic [SQ_W-1:0]        pz1_ff;
   logic [PASS_W-1:0]      pass1_ff;

   logic              v2_ff;
   logic [SQ_W-1:0]   sq2_ff;
   logic [PASS_W-1:0] pass2_ff;

   logic                sq_valid_w [ROOT_W+1];
   logic [2*ROOT_W-1:0] rad_w      [ROOT_W+1];
   logic [ROOT_W:0]     rem_w      [ROOT_W+1];
   logic [ROOT_W-1:0]   root_w     [ROOT_W+1];
   logic [PASS_W-1:0]   pass_w     [ROOT_W+1];

   logic signed [SAMPLE_WIDTH-1:0] sx;
   logic signed [SAMPLE_WIDTH-1:0] sy;
   logic signed [SAMPLE_WIDTH-1:0] sz;
   logic signed [CORD_W-1:0]       roll_x0;
   logic signed [CORD_W-1:0]       roll_y0;
   logic signed [CORD_W-1:0]       pitch_x0;
   logic signed [CORD_W-1:0]       pitch_y0;

   logic                     r_valid_w [CORDIC_STAGES+1];
   logic signed [CORD_W-1:0] r_x_w     [CORDIC_STAGES+1];
   logic signed [CORD_W-1:0] r_y_w     [CORDIC_STAGES+1];
   logic signed [ACC_W-1:0]  r_acc_w   [CORDIC_STAGES+1];
   logic                     r_zero_w  [CORDIC_STAGES+1];
   logic                     p_valid_w [CORDIC_STAGES+1];
   logic signed [CORD_W-1:0] p_x_w     [CORDIC_STAGES+1];
   logic signed [CORD_W-1:0] p_y_w     [CORDIC_STAGES+1];
   logic signed [ACC_W-1:0]  p_acc_w   [CORDIC_STAGES+1];
   logic                     p_zero_w  [CORDIC_STAGES+1];

   logic signed [ACC_W-1:0]   roll_acc;
   logic signed [ACC_W-1:0]   pitch_acc;
   logic signed [ACC_W-1:0]   roll_rnd;
   logic signed [ACC_W-1:0]   pitch_rnd;
   logic signed [ACC_W-1:0]   roll_clip;
   logic signed [ACC_W-1:0]   pitch_clip;
   logic                      rsp_valid_ff;
   logic signed [ROLL_W-1:0]  rsp_roll_ff;
   logic signed [PITCH_W-1:0] rsp_pitch_ff;

   assign adv       = !rsp_valid_ff || !rsp_stall;
   assign req_stall = !adv;

   assign py_in = y0_ff * y0_ff;
   assign pz_in = z0_ff * z0_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else if (adv) begin
         v0_ff <= req_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         x0_ff    <= req_accel_x;
         y0_ff    <= req_accel_y;
         z0_ff    <= req_accel_z;
         py1_ff   <= py_in;
         pz1_ff   <= pz_in;
         pass1_ff <= {x0_ff, y0_ff, z0_ff};
         sq2_ff   <= py1_ff + pz1_ff;
         pass2_ff <= pass1_ff;
      end
   end

   assign sq_valid_w[0] = v2_ff;
   assign rad_w[0]      = {sq2_ff, {(2*GUARD_BITS){1'b0}}};
   assign rem_w[0]      = '0;
   assign root_w[0]     = '0;
   assign pass_w[0]     = pass2_ff;

   for (genvar k = 0; k < ROOT_W; k++) begin : g_sqrt
      atrp_sqrt_cell #(
         .ROOT_W (ROOT_W),
         .PASS_W (PASS_W)
      ) u_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (sq_valid_w[k]),
         .prev_rad   (rad_w[k]),
         .prev_rem   (rem_w[k]),
         .prev_root  (root_w[k]),
         .prev_pass  (pass_w[k]),
         .valid_ff   (sq_valid_w[k+1]),
         .rad_ff     (rad_w[k+1]),
         .rem_ff     (rem_w[k+1]),
         .root_ff    (root_w[k+1]),
         .pass_ff    (pass_w[k+1])
      );
   end

   assign sx = pass_w[ROOT_W][3*SAMPLE_WIDTH-1:2*SAMPLE_WIDTH];
   assign sy = pass_w[ROOT_W][2*SAMPLE_WIDTH-1:SAMPLE_WIDTH];
   assign sz = pass_w[ROOT_W][SAMPLE_WIDTH-1:0];

   assign roll_x0  = {{3{sz[SAMPLE_WIDTH-1]}}, sz, {GUARD_BITS{1'b0}}};
   assign roll_y0  = {{3{sy[SAMPLE_WIDTH-1]}}, sy, {GUARD_BITS{1'b0}}};
   assign pitch_x0 = {3'b000, root_w[ROOT_W]};
   assign pitch_y0 = {{3{sx[SAMPLE_WIDTH-1]}}, sx, {GUARD_BITS{1'b0}}};

   atrp_prerot #(
      .CORD_W (CORD_W)
   ) u_roll_prerot (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .prev_valid (sq_valid_w[ROOT_W]),
      .prev_x     (roll_x0),
      .prev_y     (roll_y0),
      .valid_ff   (r_valid_w[0]),
      .x_ff       (r_x_w[0]),
      .y_ff       (r_y_w[0]),
      .acc_ff     (r_acc_w[0]),
      .zero_ff    (r_zero_w[0])
   );

   atrp_prerot #(
      .CORD_W (CORD_W)
   ) u_pitch_prerot (
      .clock      (clock),
      .reset      (reset),
      .en         (adv),
      .prev_valid (sq_valid_w[ROOT_W]),
      .prev_x     (pitch_x0),
      .prev_y     (pitch_y0),
      .valid_ff   (p_valid_w[0]),
      .x_ff       (p_x_w[0]),
      .y_ff       (p_y_w[0]),
      .acc_ff     (p_acc_w[0]),
      .zero_ff    (p_zero_w[0])
   );

   for (genvar i = 0; i < CORDIC_STAGES; i++) begin : g_cordic
      atrp_cordic_cell #(
         .STAGE  (i),
         .CORD_W (CORD_W)
      ) u_roll_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (r_valid_w[i]),
         .prev_x     (r_x_w[i]),
         .prev_y     (r_y_w[i]),
         .prev_acc   (r_acc_w[i]),
         .prev_zero  (r_zero_w[i]),
         .valid_ff   (r_valid_w[i+1]),
         .x_ff       (r_x_w[i+1]),
         .y_ff       (r_y_w[i+1]),
         .acc_ff     (r_acc_w[i+1]),
         .zero_ff    (r_zero_w[i+1])
      );

      atrp_cordic_cell #(
         .STAGE  (i),
         .CORD_W (CORD_W)
      ) u_pitch_cell (
         .clock      (clock),
         .reset      (reset),
         .en         (adv),
         .prev_valid (p_valid_w[i]),
         .prev_x     (p_x_w[i]),
         .prev_y     (p_y_w[i]),
         .prev_acc   (p_acc_w[i]),
         .prev_zero  (p_zero_w[i]),
         .valid_ff   (p_valid_w[i+1]),
         .x_ff       (p_x_w[i+1]),
         .y_ff       (p_y_w[i+1]),
         .acc_ff     (p_acc_w[i+1]),
         .zero_ff    (p_zero_w[i+1])
      );
   end

   // A zero vector has no direction and reads as zero degrees.
   always_comb begin
      roll_acc  = r_zero_w[CORDIC_STAGES] ? '0 : r_acc_w[CORDIC_STAGES];
      pitch_acc = p_zero_w[CORDIC_STAGES] ? '0 : p_acc_w[CORDIC_STAGES];
      roll_rnd  = (roll_acc + ROUND_HALF) >>> RND_SH;
      pitch_rnd = (pitch_acc + ROUND_HALF) >>> RND_SH;
      roll_clip = roll_rnd;
      if (roll_rnd > ROLL_LIM) begin
         roll_clip = ROLL_LIM;
      end else if (roll_rnd < -ROLL_LIM) begin
         roll_clip = -ROLL_LIM;
      end
      pitch_clip = pitch_rnd;
      if (pitch_rnd > PITCH_LIM) begin
         pitch_clip = PITCH_LIM;
      end else if (pitch_rnd < -PITCH_LIM) begin
         pitch_clip = -PITCH_LIM;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         rsp_valid_ff <= r_valid_w[CORDIC_STAGES] && p_valid_w[CORDIC_STAGES];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         rsp_roll_ff  <= roll_clip[ROLL_W-1:0];
         rsp_pitch_ff <= pitch_clip[PITCH_W-1:0];
      end
   end

   assign rsp_valid     = rsp_valid_ff;
   assign rsp_roll_deg  = rsp_roll_ff;
   assign rsp_pitch_deg = rsp_pitch_ff;

   `ATRP_ASSERT_IMPLIES(a_roll_range, clock, reset, rsp_valid_ff, (rsp_roll_ff <= ROLL_LIM) && (rsp_roll_ff >= -ROLL_LIM), "roll beat outside its range")
   `ATRP_ASSERT_IMPLIES(a_pitch_range, clock, reset, rsp_valid_ff, (rsp_pitch_ff <= PITCH_LIM) && (rsp_pitch_ff >= -PITCH_LIM), "pitch beat outside its range")
   `ATRP_ASSERT_IMPLIES(a_sqrt_rem, clock, reset, sq_valid_w[ROOT_W], rem_w[ROOT_W] <= {root_w[ROOT_W], 1'b0}, "square-root remainder exceeds twice the root")
   `ATRP_ASSERT_IMPLIES(a_right_half, clock, reset, r_valid_w[0] && p_valid_w[0], !r_x_w[0][CORD_W-1] && !p_x_w[0][CORD_W-1], "vector left in the left half plane")
   `ATRP_ASSERT_NEXT(a_chains_in_step, clock, reset, adv && sq_valid_w[ROOT_W], r_valid_w[0] && p_valid_w[0], "CORDIC chains lost a beat")

endmodule

`default_nettype wire
